// ===== src/vwdp_pkg.sv =====
// ----------------------------------------------------------------------------
// vwdp_pkg
// Shared constants and types for the valid-weighted depth pyramid.
// ----------------------------------------------------------------------------
package vwdp_pkg;
    localparam int MAX_LEVELS_DEF = 5;
    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int DEPTH_BITS_DEF = 16;
    localparam int SIZE_W   = 13;
    localparam int LVL_W    = 3;
    localparam int POS_W    = 11;
    localparam int WGT_W    = 9;
    localparam int SUM_W    = 24;
    localparam int PW_W     = 8;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_LEVELS = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;
endpackage

// ===== src/valid_weighted_depth_pyramid_unit.sv =====
// ----------------------------------------------------------------------------
// valid_weighted_depth_pyramid_unit
// Streaming 2x2 valid-weighted mean pyramid over a raster depth image.
// ----------------------------------------------------------------------------
// Each accepted pixel walks up the levels one at a time, and no new pixel
// is accepted until it is done. A level step reads the upper-pair store; a
// finished 2x2 block then combines with the stored pair as it loads a
// restoring divider of 24 steps. A reduced pixel waits in the output
// register, not yet valid, until the next level resolves and its
// last-of-run flag is known. The write of a quotient into the output
// register stalls while that register still holds an unaccepted word.
// The upper-pair store is one synchronous memory of MAX_WIDTH entries,
// shared by all levels.
module valid_weighted_depth_pyramid_unit #(
    parameter int MAX_LEVELS = vwdp_pkg::MAX_LEVELS_DEF,
    parameter int MAX_WIDTH  = vwdp_pkg::MAX_WIDTH_DEF,
    parameter int DEPTH_BITS = vwdp_pkg::DEPTH_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [15:0]                         s_depth_in,
    input  logic                                s_frame_start,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [vwdp_pkg::LVL_W-1:0]          m_out_level,
    output logic [vwdp_pkg::POS_W-1:0]          m_out_column,
    output logic [vwdp_pkg::POS_W-1:0]          m_out_row,
    output logic [15:0]                         m_out_depth,
    output logic [vwdp_pkg::WGT_W-1:0]          m_valid_weight,
    output logic                                m_last_of_run
);
    import vwdp_pkg::*;

    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int LIW = $clog2(MAX_LEVELS);
    localparam int CW  = SIZE_W;

    logic [SIZE_W-1:0] width_reg, height_reg;
    logic [LVL_W-1:0]  levels_reg;
    logic              wr_en;
    logic [1:0]        reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= SIZE_W'(640);
            height_reg <= SIZE_W'(480);
            levels_reg <= LVL_W'(5);
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_WIDTH:  width_reg  <= pwdata[SIZE_W-1:0];
                REG_HEIGHT: height_reg <= pwdata[SIZE_W-1:0];
                REG_LEVELS: levels_reg <= pwdata[LVL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_WIDTH:  prdata = 32'(width_reg);
            REG_HEIGHT: prdata = 32'(height_reg);
            REG_LEVELS: prdata = 32'(levels_reg);
            default:    prdata = '0;
        endcase
    end

    logic [SIZE_W-1:0] fw, fh;
    logic [LVL_W-1:0]  levels;
    assign fw = ({1'b0, width_reg} > (SIZE_W+1)'(MAX_WIDTH)) ? SIZE_W'(MAX_WIDTH) : width_reg;
    assign fh = ({1'b0, height_reg} > (SIZE_W+1)'(MAX_WIDTH)) ? SIZE_W'(MAX_WIDTH) : height_reg;
    always_comb begin
        levels = levels_reg;
        if (levels == '0) levels = LVL_W'(1);
        if (levels > LVL_W'(MAX_LEVELS)) levels = LVL_W'(MAX_LEVELS);
    end

    // upper-pair store
    logic [SUM_W+PW_W-1:0] mem [MAX_WIDTH];
    logic [SUM_W+PW_W-1:0] mem_rdata;
    logic                  mem_we;
    logic [AW-1:0]         mem_addr;
    logic [SUM_W+PW_W-1:0] mem_wdata;

    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_addr] <= mem_wdata;
        mem_rdata <= mem[mem_addr];
    end

    state_t state_reg, state_next;
    logic [LIW-1:0]   lv_reg;
    logic [CW-1:0]    col_reg [MAX_LEVELS];
    logic [CW-1:0]    row_reg [MAX_LEVELS];
    logic [SUM_W-1:0] pls_reg [MAX_LEVELS];
    logic [PW_W-1:0]  plw_reg [MAX_LEVELS];
    logic [15:0]      d_reg;
    logic [WGT_W-1:0] w_reg;
    logic             hold_valid_reg;
    logic [POS_W-1:0] blk_col_reg;
    logic [POS_W-1:0] blk_row_reg;
    logic [SUM_W-1:0] psum_reg;
    logic [PW_W-1:0]  pw_reg;
    logic [SUM_W-1:0] rem_reg;
    logic [SUM_W-1:0] quo_reg;
    logic [4:0]       dcnt_reg;

    logic [CW-1:0]     c, r;
    logic [SIZE_W-1:0] wl, hl;
    logic              in_blk, last_lv, take_blk, emit;
    logic [PW_W-1:0]   pw_c;
    logic [AW:0]       idx_full;
    logic [SUM_W-1:0]  tot_sum;
    logic [WGT_W-1:0]  tot_w;
    logic [SUM_W-1:0]  prod_c;
    logic [SUM_W-1:0]  psum_m;

    assign c  = col_reg[lv_reg];
    assign r  = row_reg[lv_reg];
    assign wl = fw >> lv_reg;
    assign hl = fh >> lv_reg;
    assign last_lv = (LVL_W'(lv_reg) + LVL_W'(1)) >= levels;
    assign in_blk  = (c < (wl & ~SIZE_W'(1))) && (r < (hl & ~SIZE_W'(1)));
    assign take_blk = !last_lv && in_blk && c[0] && r[0];
    assign prod_c  = SUM_W'(d_reg) * SUM_W'(w_reg);
    assign psum_m  = prod_c + pls_reg[lv_reg];
    assign pw_c    = PW_W'(w_reg) + plw_reg[lv_reg];
    assign idx_full = (AW+1)'(MAX_WIDTH) - ((AW+1)'(MAX_WIDTH) >> lv_reg) + (AW+1)'(c >> 1);
    assign mem_addr = (idx_full >= (AW+1)'(MAX_WIDTH)) ? AW'(MAX_WIDTH - 1) : idx_full[AW-1:0];
    assign mem_wdata = {psum_m, pw_c};
    assign mem_we   = (state_reg == ST_READ) && !stage_b_reg && !last_lv && in_blk
                      && c[0] && !r[0];
    assign tot_sum  = psum_reg + mem_rdata[SUM_W+PW_W-1:PW_W];
    assign tot_w    = WGT_W'(pw_reg) + WGT_W'(mem_rdata[PW_W-1:0]);

    logic stage_b_reg;
    logic out_full;
    assign out_full = m_valid && !m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign emit     = (state_reg == ST_READ) && !stage_b_reg && hold_valid_reg;

    logic [SUM_W+WGT_W-1:0] trial;
    assign trial = {rem_reg, quo_reg[SUM_W-1]} - {{SUM_W{1'b0}}, w_reg} ;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            lv_reg         <= '0;
            hold_valid_reg <= 1'b0;
            stage_b_reg    <= 1'b0;
            m_valid        <= 1'b0;
            for (int i = 0; i < MAX_LEVELS; i++) begin
                col_reg[i] <= '0;
                row_reg[i] <= '0;
                pls_reg[i] <= '0;
                plw_reg[i] <= '0;
            end
        end else begin
            if (emit) m_valid <= 1'b1;
            else if (m_ready) m_valid <= 1'b0;
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        if (s_frame_start) begin
                            for (int i = 0; i < MAX_LEVELS; i++) begin
                                col_reg[i] <= '0;
                                row_reg[i] <= '0;
                                pls_reg[i] <= '0;
                                plw_reg[i] <= '0;
                            end
                        end
                        d_reg       <= s_depth_in & 16'((17'd1 << DEPTH_BITS) - 17'd1);
                        w_reg       <= WGT_W'((s_depth_in & 16'((17'd1 << DEPTH_BITS) - 17'd1))
                                              != 16'd0);
                        lv_reg      <= '0;
                        stage_b_reg <= 1'b0;
                        state_reg   <= ST_READ;
                    end
                end
                ST_READ: begin
                    if (!stage_b_reg) begin
                        if (hold_valid_reg) begin
                            m_last_of_run  <= !take_blk;
                            hold_valid_reg <= 1'b0;
                        end
                        if (c + CW'(1) >= wl) begin
                            col_reg[lv_reg] <= '0;
                            row_reg[lv_reg] <= (r + CW'(1) >= hl) ? '0 : r + CW'(1);
                        end else begin
                            col_reg[lv_reg] <= c + CW'(1);
                        end
                        if (last_lv || !in_blk) begin
                            state_reg <= ST_OUT;
                        end else if (!c[0]) begin
                            pls_reg[lv_reg] <= prod_c;
                            plw_reg[lv_reg] <= PW_W'(w_reg);
                            state_reg <= ST_OUT;
                        end else if (!r[0]) begin
                            state_reg <= ST_OUT;
                        end else begin
                            psum_reg    <= psum_m;
                            pw_reg      <= pw_c;
                            stage_b_reg <= 1'b1;
                            blk_col_reg <= POS_W'(c >> 1);
                            blk_row_reg <= POS_W'(r >> 1);
                        end
                    end else begin
                        w_reg    <= tot_w;
                        quo_reg  <= tot_sum;
                        rem_reg  <= '0;
                        dcnt_reg <= 5'(SUM_W);
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (dcnt_reg != '0) begin
                        dcnt_reg <= dcnt_reg - 5'd1;
                        if (!trial[SUM_W+WGT_W-1] && w_reg != '0) begin
                            rem_reg <= trial[SUM_W-1:0];
                            quo_reg <= {quo_reg[SUM_W-2:0], 1'b1};
                        end else begin
                            rem_reg <= {rem_reg[SUM_W-2:0], quo_reg[SUM_W-1]};
                            quo_reg <= {quo_reg[SUM_W-2:0], 1'b0};
                        end
                    end else if (!out_full) begin
                        m_out_level    <= LVL_W'(lv_reg) + LVL_W'(1);
                        m_out_column   <= blk_col_reg;
                        m_out_row      <= blk_row_reg;
                        m_out_depth    <= (w_reg == '0) ? 16'd0 : quo_reg[15:0];
                        m_valid_weight <= w_reg;
                        d_reg          <= (w_reg == '0) ? 16'd0 : quo_reg[15:0];
                        hold_valid_reg <= 1'b1;
                        stage_b_reg    <= 1'b0;
                        lv_reg         <= lv_reg + LIW'(1);
                        state_reg      <= ST_READ;
                    end
                end
                ST_OUT: begin
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid);
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable({m_out_level, m_out_column, m_out_row,
                                         m_out_depth, m_valid_weight, m_last_of_run}));
    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg));
    assert property (@(posedge aclk) disable iff (!aresetn)
        hold_valid_reg |-> !m_valid);
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !hold_valid_reg);
endmodule
